// ===== rtl/olsr_pkg.sv =====
`default_nettype none

package olsr_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned OP_W     = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned POS_W    = 4;
    localparam int unsigned TOTAL_W  = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_PEEK_FRONT = 3'd2,
        OP_PEEK_BACK  = 3'd3,
        OP_POP_FRONT  = 3'd4,
        OP_POP_BACK   = 3'd5,
        OP_SEARCH     = 3'd6,
        OP_REMOVE     = 3'd7
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_FULL     = 2'd2,
        ST_NOTFOUND = 2'd3
    } status_t;

    // Command broadcast to every cell of the row.
    typedef enum logic [2:0] {
        CMD_HOLD       = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_PUSH_BACK  = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_POP_BACK   = 3'd4,
        CMD_REMOVE     = 3'd5
    } cell_cmd_t;

    typedef struct packed {
        status_t                   status;
        logic signed [DATA_W-1:0]  result_value;
        logic [POS_W-1:0]          position;
        logic [TOTAL_W-1:0]        entry_total;
        logic                      is_empty;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/olsr_if.sv =====
`default_nettype none

interface olsr_req_if
    import olsr_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           op;
    logic signed [DATA_W-1:0]  value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

interface olsr_rsp_if
    import olsr_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic signed [DATA_W-1:0]  result_value;
    logic [POS_W-1:0]          position;
    logic [TOTAL_W-1:0]        entry_total;
    logic                      is_empty;

    modport source (output valid, output status, output result_value, output position,
                    output entry_total, output is_empty, input ready);
    modport sink   (input valid, input status, input result_value, input position,
                    input entry_total, input is_empty, output ready);
endinterface

`default_nettype wire

// ===== rtl/olsr_cell.sv =====
`default_nettype none

module olsr_cell
    import olsr_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire cell_cmd_t                 cmd,
    input  wire logic signed [DATA_W-1:0]  key,
    input  wire logic signed [DATA_W-1:0]  left_value,
    input  wire logic                      left_valid,
    input  wire logic signed [DATA_W-1:0]  right_value,
    input  wire logic                      right_valid,
    input  wire logic                      prior_hit,
    output logic signed [DATA_W-1:0]       value,
    output logic                           valid,
    output logic                           hit_chain,
    output logic                           first_hit,
    output logic                           is_last
);

    logic signed [DATA_W-1:0] value_reg, value_next;
    logic                     valid_reg, valid_next;
    logic                     hit;

    assign hit       = valid_reg && (value_reg == key);
    assign hit_chain = prior_hit || hit;
    assign first_hit = hit && !prior_hit;
    assign is_last   = valid_reg && !right_valid;
    assign value     = value_reg;
    assign valid     = valid_reg;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        unique case (cmd)
            CMD_HOLD:
            begin
            end
            CMD_PUSH_FRONT:
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            CMD_PUSH_BACK:
            begin
                // first empty slot right after the tail takes the key
                if (!valid_reg && left_valid)
                begin
                    value_next = key;
                    valid_next = 1'b1;
                end
            end
            CMD_POP_FRONT:
            begin
                value_next = right_value;
                valid_next = right_valid;
            end
            CMD_POP_BACK:
            begin
                if (is_last)
                begin
                    valid_next = 1'b0;
                end
            end
            CMD_REMOVE:
            begin
                // the first match and everything behind it close the gap
                if (hit_chain)
                begin
                    value_next = right_value;
                    valid_next = right_valid;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

// ===== rtl/ordered_list_with_search_remove_unit.sv =====
`default_nettype none

// Channel | Dir | Fields                                              | Transfer
// req     | in  | op[2:0], value[31:0]                                | valid && ready
// rsp     | out | status[1:0], result_value[31:0], position[3:0],     | valid && ready
//         |     | entry_total[4:0], is_empty                          |
//
// One item per cycle while req.ready is high: the cell row compares all entries in parallel and
// shifts in the cycle the request transfers; the result lands in the output
// register on the next edge.
// req.ready stays high while the output register is empty or being drained.
// Reset clears the valid bits of all cells and the entry count; no sweep.

module ordered_list_with_search_remove_unit
    import olsr_pkg::*;
#(
    parameter int unsigned LIST_DEPTH = 16
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    olsr_req_if.sink   req,
    olsr_rsp_if.source rsp
);

    localparam int unsigned IDX_W  = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(LIST_DEPTH + 1);
    localparam int unsigned IDXE_W = (IDX_W > POS_W) ? IDX_W : POS_W;
    localparam int unsigned CNTE_W = (CNT_W > TOTAL_W) ? CNT_W : TOTAL_W;

    cell_cmd_t                 cmd;
    logic signed [DATA_W-1:0]  cell_value [LIST_DEPTH];
    logic [LIST_DEPTH-1:0]     cell_valid;
    logic [LIST_DEPTH-1:0]     cell_hit_chain;
    logic [LIST_DEPTH-1:0]     cell_first;
    logic [LIST_DEPTH-1:0]     cell_last;

    logic [CNT_W-1:0]          count_reg, count_next;
    logic                      out_valid_reg;
    result_t                   result_reg, result_next;

    logic                      accept;
    logic                      full;
    logic                      empty;
    logic                      found;
    logic signed [DATA_W-1:0]  back_value;
    logic [IDXE_W-1:0]         hit_idx;
    logic [CNTE_W-1:0]         count_ext;

    genvar gi;
    generate
        for (gi = 0; gi < LIST_DEPTH; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] lv, rv;
            logic                     lval, rval, prior;
            if (gi == 0)
            begin : g_head
                assign lv    = req.value;
                assign lval  = 1'b1;
                assign prior = 1'b0;
            end
            else
            begin : g_body
                assign lv    = cell_value[gi-1];
                assign lval  = cell_valid[gi-1];
                assign prior = cell_hit_chain[gi-1];
            end
            if (gi == LIST_DEPTH - 1)
            begin : g_tail
                assign rv   = '0;
                assign rval = 1'b0;
            end
            else
            begin : g_inner
                assign rv   = cell_value[gi+1];
                assign rval = cell_valid[gi+1];
            end

            olsr_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .cmd         (cmd),
                .key         (req.value),
                .left_value  (lv),
                .left_valid  (lval),
                .right_value (rv),
                .right_valid (rval),
                .prior_hit   (prior),
                .value       (cell_value[gi]),
                .valid       (cell_valid[gi]),
                .hit_chain   (cell_hit_chain[gi]),
                .first_hit   (cell_first[gi]),
                .is_last     (cell_last[gi])
            );
        end
    endgenerate

    assign req.ready = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign full      = (count_reg == CNT_W'(LIST_DEPTH));
    assign empty     = (count_reg == '0);
    assign found     = cell_hit_chain[LIST_DEPTH-1];

    // one-hot selects, so plain OR reductions
    always_comb
    begin
        back_value = '0;
        hit_idx    = '0;
        for (int i = 0; i < LIST_DEPTH; i++)
        begin
            if (cell_last[i])
            begin
                back_value = back_value | cell_value[i];
            end
            if (cell_first[i])
            begin
                hit_idx = hit_idx | IDXE_W'(i);
            end
        end
    end

    always_comb
    begin
        cmd                      = CMD_HOLD;
        count_next               = count_reg;
        result_next              = '0;
        result_next.status       = ST_OK;
        if (accept)
        begin
            unique case (op_t'(req.op))
                OP_PUSH_FRONT, OP_PUSH_BACK:
                begin
                    if (full)
                    begin
                        result_next.status = ST_FULL;
                    end
                    else
                    begin
                        cmd        = (op_t'(req.op) == OP_PUSH_FRONT) ? CMD_PUSH_FRONT
                                                                       : CMD_PUSH_BACK;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                OP_PEEK_FRONT, OP_POP_FRONT:
                begin
                    if (empty)
                    begin
                        result_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        result_next.result_value = cell_value[0];
                        if (op_t'(req.op) == OP_POP_FRONT)
                        begin
                            cmd        = CMD_POP_FRONT;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                OP_PEEK_BACK, OP_POP_BACK:
                begin
                    if (empty)
                    begin
                        result_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        result_next.result_value = back_value;
                        if (op_t'(req.op) == OP_POP_BACK)
                        begin
                            cmd        = CMD_POP_BACK;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                OP_SEARCH, OP_REMOVE:
                begin
                    if (!found)
                    begin
                        result_next.status = ST_NOTFOUND;
                    end
                    else
                    begin
                        // a match equals the key
                        result_next.result_value = req.value;
                        result_next.position     = hit_idx[POS_W-1:0];
                        if (op_t'(req.op) == OP_REMOVE)
                        begin
                            cmd        = CMD_REMOVE;
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        count_ext               = CNTE_W'(count_next);
        result_next.entry_total = count_ext[TOTAL_W-1:0];
        result_next.is_empty    = (count_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = result_reg.status;
    assign rsp.result_value = result_reg.result_value;
    assign rsp.position     = result_reg.position;
    assign rsp.entry_total  = result_reg.entry_total;
    assign rsp.is_empty     = result_reg.is_empty;

`ifndef ASSERT_OFF
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(LIST_DEPTH))
        else $error("entry count above list depth");

    a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == 32'(count_reg))
        else $error("entry count disagrees with valid cells");

    a_packed_row: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_last))
        else $error("cell row has a hole");

    a_single_first: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_first))
        else $error("more than one first match");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !full && (op_t'(req.op) == OP_PUSH_FRONT || op_t'(req.op) == OP_PUSH_BACK)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("push did not add an entry");
`endif

endmodule

`default_nettype wire

// ===== test/ordered_list_with_search_remove_unit_tb.sv =====
module ordered_list_with_search_remove_unit_tb
    import olsr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_CAP       = 16;
    localparam int RANDOM_ITEMS   = 1100;
    localparam int HOLD_CYCLES    = 80;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int REPORT_LIMIT   = 10;

    logic clk;
    logic rst_n;

    olsr_req_if req_ch ();
    olsr_rsp_if rsp_ch ();

    ordered_list_with_search_remove_unit #(
        .LIST_DEPTH (LIST_CAP)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Shadow copy of the list contents, front at index 0.
    logic signed [DATA_W-1:0] list_model [$];
    result_t                  list_outcomes_due [$];

    int fault_count  = 0;
    int idle_cycles  = 0;
    int burst_left   = 0;
    bit pace_on      = 1'b1;

    // Receiver stall control.
    int       rsp_mode    = 0;
    int       mode_left   = 0;
    logic [7:0] stall_pat = 8'h01;
    int       hold_asked  = 0;
    int       hold_served = 0;
    int       hold_left   = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic result_t apply_list_op(input op_t op,
                                              input logic signed [DATA_W-1:0] v);
        result_t r;
        int      hit;
        r        = '0;
        r.status = ST_OK;
        hit      = -1;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (list_model.size() >= LIST_CAP)
                    r.status = ST_FULL;
                else if (op == OP_PUSH_FRONT)
                    list_model.push_front(v);
                else
                    list_model.push_back(v);
            end
            OP_PEEK_FRONT, OP_POP_FRONT:
            begin
                if (list_model.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.result_value = list_model[0];
                    if (op == OP_POP_FRONT)
                        void'(list_model.pop_front());
                end
            end
            OP_PEEK_BACK, OP_POP_BACK:
            begin
                if (list_model.size() == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    r.result_value = list_model[list_model.size() - 1];
                    if (op == OP_POP_BACK)
                        void'(list_model.pop_back());
                end
            end
            default:
            begin
                // first match nearest the front wins
                for (int i = 0; i < list_model.size(); i++)
                begin
                    if (list_model[i] == v)
                    begin
                        hit = i;
                        break;
                    end
                end
                if (hit < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    r.result_value = list_model[hit];
                    r.position     = POS_W'(hit);
                    if (op == OP_REMOVE)
                        list_model.delete(hit);
                end
            end
        endcase
        r.entry_total = TOTAL_W'(list_model.size());
        r.is_empty    = (list_model.size() == 0);
        return r;
    endfunction

    function automatic void note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%t ERROR: %s", $realtime, msg);
    endfunction

    task automatic check_outcome(input result_t got);
        result_t want;
        if (list_outcomes_due.size() == 0)
        begin
            note_fault($sformatf("unexpected result: st=%0d val=%0d pos=%0d tot=%0d emp=%0d",
                                 got.status, got.result_value, got.position,
                                 got.entry_total, got.is_empty));
        end
        else
        begin
            want = list_outcomes_due.pop_front();
            if (got.status !== want.status || got.result_value !== want.result_value ||
                got.position !== want.position || got.entry_total !== want.entry_total ||
                got.is_empty !== want.is_empty)
            begin
                note_fault($sformatf({"exp st=%0d val=%0d pos=%0d tot=%0d emp=%0d, ",
                                      "got st=%0d val=%0d pos=%0d tot=%0d emp=%0d"},
                                     want.status, want.result_value, want.position,
                                     want.entry_total, want.is_empty,
                                     got.status, got.result_value, got.position,
                                     got.entry_total, got.is_empty));
            end
        end
    endtask

    // Inputs only move at the rising edge, so the negedge view equals the edge view.
    always @(negedge clk)
    begin
        result_t got;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            got.status       = status_t'(rsp_ch.status);
            got.result_value = rsp_ch.result_value;
            got.position     = rsp_ch.position;
            got.entry_total  = rsp_ch.entry_total;
            got.is_empty     = rsp_ch.is_empty;
            check_outcome(got);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%t ERROR: no transfer for %0d cycles", $realtime, idle_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // Receiver: stall pattern changes every so often; a requested hold-off
    // keeps ready low for a long stretch.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (mode_left == 0)
            begin
                rsp_mode  <= $urandom_range(0, 3);
                mode_left <= $urandom_range(32, 200);
                stall_pat <= 8'($urandom) | 8'h01;
            end
            else
            begin
                mode_left <= mode_left - 1;
                stall_pat <= {stall_pat[0], stall_pat[7:1]};
            end

            if (hold_served != hold_asked)
            begin
                hold_served   <= hold_asked;
                hold_left     <= HOLD_CYCLES;
                rsp_ch.ready  <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left    <= hold_left - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (rsp_mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    2:       rsp_ch.ready <= ($urandom_range(0, 9) != 0);
                    default: rsp_ch.ready <= stall_pat[0];
                endcase
            end
        end
        else
        begin
            rsp_ch.ready <= 1'b0;
        end
    end

    task automatic send_item(input op_t op, input logic signed [DATA_W-1:0] v);
        int unsigned gap;
        logic        rdy;
        if (pace_on && burst_left == 0)
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        if (burst_left != 0)
            burst_left--;
        req_ch.valid <= 1'b1;
        req_ch.op    <= op;
        req_ch.value <= v;
        do
        begin
            @(negedge clk);
            rdy = req_ch.ready;
            @(posedge clk);
        end
        while (rdy !== 1'b1);
        list_outcomes_due.push_back(apply_list_op(op, v));
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $signed(DATA_W'($urandom_range(0, 8))) - 4;    // dense pool -> duplicates
        else if (r < 60 && list_model.size() != 0)
            return list_model[$urandom_range(0, list_model.size() - 1)];
        else if (r < 70)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7FFF_FFFF;
                1:       return 32'sh8000_0000;
                2:       return 32'sh0000_0000;
                default: return -32'sd1;
            endcase
        end
        else
            return $signed(DATA_W'($urandom));
    endfunction

    function automatic op_t pick_op(input int push_pct);
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        return op_t'($urandom_range(OP_PEEK_FRONT, OP_REMOVE));
    endfunction

    function automatic logic signed [DATA_W-1:0] operand_for(input op_t op);
        // search and remove mostly aim at something present
        if ((op == OP_SEARCH || op == OP_REMOVE) && list_model.size() != 0 &&
            $urandom_range(0, 9) < 7)
            return list_model[$urandom_range(0, list_model.size() - 1)];
        return pick_value();
    endfunction

    task automatic test_empty_list();
        send_item(OP_PEEK_FRONT, 32'sd11);
        send_item(OP_PEEK_BACK, 32'sd12);
        send_item(OP_POP_FRONT, -32'sd13);
        send_item(OP_POP_BACK, 32'sd14);
        send_item(OP_SEARCH, 32'sd0);
        send_item(OP_REMOVE, 32'sd0);
    endtask

    task automatic test_fill_and_overflow();
        logic signed [DATA_W-1:0] fill_vals [LIST_CAP] = '{
            32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, -32'sd1,
            32'sh5555_5555, 32'shAAAA_AAAA, 32'sd5, 32'sd1,
            32'sd5, -32'sd5, 32'sh7FFF_FFFF, 32'sd2,
            32'sd100, -32'sd100, 32'sd3, 32'sd7};
        for (int i = 0; i < LIST_CAP; i++)
            send_item((i % 2 == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT, fill_vals[i]);
        send_item(OP_PUSH_FRONT, 32'sd9);
        send_item(OP_PUSH_BACK, 32'sd9);
        send_item(OP_SEARCH, 32'sd5);
        send_item(OP_REMOVE, 32'sd5);
        send_item(OP_SEARCH, 32'sd5);
        send_item(OP_REMOVE, 32'sd12345);
    endtask

    task automatic test_backpressure();
        op_t op;
        pace_on = 1'b0;
        hold_asked++;
        for (int i = 0; i < 40; i++)
        begin
            op = pick_op(60);
            send_item(op, operand_for(op));
        end
        pace_on = 1'b1;
    endtask

    task automatic test_random_mix();
        int  push_bias [6] = '{75, 45, 15, 30, 90, 10};
        int  phase;
        op_t op;
        phase = 0;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // swing the fill level between empty and full
            if (i % 90 == 0)
                phase = $urandom_range(0, 5);
            if ($urandom_range(0, 9) == 0)
                op = op_t'($urandom_range(OP_PUSH_FRONT, OP_REMOVE));
            else
                op = pick_op(push_bias[phase]);
            send_item(op, operand_for(op));
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.op    = OP_PUSH_FRONT;
        req_ch.value = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_fill_and_overflow();
        test_backpressure();
        test_random_mix();

        req_ch.valid <= 1'b0;
        while (list_outcomes_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
